// File: hdl/msi_interrupt_file_assert.svh
// Assertion macros for the interrupt file.
`ifndef MSI_INTERRUPT_FILE_ASSERT_SVH
`define MSI_INTERRUPT_FILE_ASSERT_SVH
// Assert that an antecedent implies a consequent in the same cycle.
`define MIF_ASSERT_IMP(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
// Assert that an antecedent implies a consequent in the next cycle.
`define MIF_ASSERT_NXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// File: hdl/mif_pkg.sv
// Package with types and constants of the interrupt file.
package mif_pkg;
  localparam int NUM_IDS = 256;
  localparam int NUM_WORDS = NUM_IDS / 32;
  localparam int WA_W = $clog2(NUM_WORDS);
  localparam logic [1:0] CMD_RD = 2'd0;
  localparam logic [1:0] CMD_WR = 2'd1;
  localparam logic [1:0] CMD_MSG = 2'd2;
  localparam logic [7:0] SEL_DELIVERY = 8'h70;
  localparam logic [7:0] SEL_THRESHOLD = 8'h72;
  localparam logic [31:0] APLIC_VALUE = 32'h4000_0000;
  localparam logic [1:0] REG_THR_MASK = 2'd0;
  localparam logic [1:0] REG_APLIC = 2'd1;
  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  sel;
    logic [3:0]  access_bytes;
    logic [11:0] page_offset;
    logic [63:0] wdata;
  } in_t;
  typedef struct packed {
    logic        ok;
    logic [63:0] rdata;
    logic [7:0]  top_id;
    logic        irq;
  } out_t;
endpackage

// File: hdl/msi_interrupt_file.sv
// Top level of the interrupt file: register access, message writes and top identity search.
// A transaction passes through READ, MOD, SCAN and DONE before out_valid rises. The READ
// state reads a word of the pending and enable memories (one word wide, 32 identities per
// word) and the MOD state modifies and writes it back. A 64-bit array access runs this pair
// twice. Then a scan reads every word once through the same memory read port, one word per
// cycle, and checks each registered word in the following cycle to find the lowest pending
// and enabled identity below the threshold. The DONE state then loads the result register.
// in_stall is high while a transaction is at work or a result waits, so a new transaction
// is taken only once the last one is through and its result has been taken. out_valid
// holds the result until taken. Configuration writes over the APB port take effect at
// once; pready is always high.
`include "msi_interrupt_file_assert.svh"
module msi_interrupt_file (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  mif_pkg::in_t       in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output mif_pkg::out_t      out_data,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [2:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001, S_READ = 5'b00010, S_MOD = 5'b00100,
    S_SCAN = 5'b01000, S_DONE = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  mif_pkg::in_t req_r;
  logic [7:0] thr_mask_r, thr_r;
  logic aplic_r;
  logic [30:0] deliv_r;
  logic [7:0] top_r;
  logic [mif_pkg::NUM_WORDS-1:0] pvalid_r;  // word written since reset, else reads zero
  logic [mif_pkg::NUM_WORDS-1:0] evalid_r;
  logic [31:0] pmem [mif_pkg::NUM_WORDS];
  logic [31:0] emem [mif_pkg::NUM_WORDS];
  logic [31:0] pq_r, eq_r;
  logic [mif_pkg::WA_W-1:0] raddr, waddr_r;
  logic [mif_pkg::WA_W:0] scan_r;
  logic [mif_pkg::WA_W-1:0] scan_q_r;
  logic scan_q_v_r, found_r;
  logic ok_r;
  logic [63:0] rdata_r;
  logic out_v_r;
  logic word_in_r;
  mif_pkg::out_t out_r;

  // ---- configuration port
  logic cfg_wr;
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel & cfg_penable & cfg_pwrite;
  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == mif_pkg::REG_THR_MASK[0]) cfg_prdata = {24'd0, thr_mask_r};
    else cfg_prdata = {31'd0, aplic_r};
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_mask_r <= 8'hFF;
      aplic_r <= 1'b0;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == mif_pkg::REG_THR_MASK[0]) thr_mask_r <= cfg_pwdata[7:0];
      else if (cfg_paddr[2] == mif_pkg::REG_APLIC[0]) aplic_r <= cfg_pwdata[0];
    end
  end

  // ---- request decode (from held request)
  logic sz_ok, is_arr, is_pend, odd_bad, reg_ok, arr_hit, hit64;
  logic [5:0] woff;
  logic msg_hit;
  logic [31:0] msg_id;
  always_comb begin
    sz_ok = req_r.access_bytes == 4'd4 || req_r.access_bytes == 4'd8;
    is_arr = req_r.sel[7];
    is_pend = ~req_r.sel[6];
    woff = req_r.sel[5:0];
    odd_bad = is_arr && req_r.access_bytes == 4'd8 && woff[0];
    reg_ok = sz_ok && !odd_bad &&
             (is_arr || req_r.sel[7:4] == 4'h7 || req_r.sel[7:4] == 4'h3);
    hit64 = is_arr && req_r.access_bytes == 4'd8;
    arr_hit = is_arr && reg_ok;
    msg_id = req_r.wdata[31:0];
    if (req_r.page_offset == 12'd4)
      msg_id = {msg_id[7:0], msg_id[15:8], msg_id[23:16], msg_id[31:24]};
    msg_hit = (req_r.page_offset == 12'd0 || req_r.page_offset == 12'd4) &&
              msg_id != 32'd0 && msg_id < 32'(mif_pkg::NUM_IDS);
  end

  // word touched: first half of a 64-bit access, then second in a second read-modify pass
  logic [1:0] half_r;
  always_comb begin
    if (req_r.cmd == mif_pkg::CMD_MSG) raddr = msg_id[5 + mif_pkg::WA_W - 1:5];
    else raddr = woff[mif_pkg::WA_W-1:0] + mif_pkg::WA_W'(half_r[0]);
    if (state_r == S_SCAN || state_r == S_MOD) raddr = scan_r[mif_pkg::WA_W-1:0];
  end

  logic mem_rd, word_in;
  logic [mif_pkg::WA_W-1:0] mem_ra;
  always_comb begin
    mem_rd = 1'b0;
    mem_ra = raddr;
    word_in = 1'b1;
    if (state_r == S_READ) begin
      mem_rd = 1'b1;
      word_in = (req_r.cmd == mif_pkg::CMD_MSG) ? 1'b1 :
                ((woff + 6'(half_r[0])) < 6'(mif_pkg::NUM_WORDS));
    end else if (state_r == S_SCAN) begin
      mem_rd = scan_r < (mif_pkg::WA_W+1)'(mif_pkg::NUM_WORDS);
    end
  end

  logic [31:0] pw, ew;
  always_comb begin
    pw = pvalid_r[waddr_r] ? pq_r : 32'd0;
    ew = evalid_r[waddr_r] ? eq_r : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (mem_rd) begin
      pq_r <= pmem[mem_ra];
      eq_r <= emem[mem_ra];
    end
  end

  // write back word
  logic wen_p, wen_e, ww_v;
  logic [31:0] wword;
  logic [31:0] wsrc;
  always_comb begin
    wen_p = 1'b0;
    wen_e = 1'b0;
    wsrc = half_r[0] ? req_r.wdata[63:32] : req_r.wdata[31:0];
    wword = wsrc;
    ww_v = state_r == S_MOD && half_r[1];
    if (ww_v) begin
      if (req_r.cmd == mif_pkg::CMD_MSG) begin
        wen_p = msg_hit && req_r.access_bytes == 4'd4;
        wword = pw | (32'd1 << msg_id[4:0]);
      end else if (req_r.cmd == mif_pkg::CMD_WR && arr_hit && word_in_r) begin
        if (waddr_r == '0) wword[0] = 1'b0;
        wen_p = is_pend;
        wen_e = !is_pend;
      end
    end
  end
  always_ff @(posedge clk) begin
    if (wen_p) pmem[waddr_r] <= wword;
    if (wen_e) emem[waddr_r] <= wword;
  end

  // ---- scan: lowest set bit of a word
  logic [31:0] cand;
  logic [4:0] lsb;
  logic lsb_v;
  logic [7:0] cand_base;
  always_comb begin
    cand = (pvalid_r[scan_q_r] ? pq_r : 32'd0) & (evalid_r[scan_q_r] ? eq_r : 32'd0);
    lsb = '0;
    lsb_v = 1'b0;
    for (int i = 31; i >= 0; i--) begin
      if (cand[i]) begin
        lsb = 5'(i);
        lsb_v = 1'b1;
      end
    end
    cand_base = 8'({scan_q_r, lsb});
  end

  // ---- control
  logic [31:0] dwv;
  always_comb begin
    dwv = req_r.wdata[31:0];
    // a nonzero upper word never matches the aplic value; keep bit 0 only
    if (req_r.access_bytes == 4'd8 && req_r.wdata[63:32] != 32'd0)
      dwv = {31'd0, req_r.wdata[0]};
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid && !in_stall) state_nxt = S_READ;
      S_READ: state_nxt = S_MOD;
      S_MOD:  state_nxt = (hit64 && req_r.cmd != mif_pkg::CMD_MSG && !half_r[0]
                           && arr_hit) ? S_READ : S_SCAN;
      S_SCAN: if (!scan_q_v_r && scan_r == (mif_pkg::WA_W+1)'(mif_pkg::NUM_WORDS))
                state_nxt = S_DONE;
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_stall = (state_r != S_IDLE) || out_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pvalid_r <= '0;
      evalid_r <= '0;
      deliv_r <= '0;
      thr_r <= '0;
      top_r <= '0;
      out_v_r <= 1'b0;
      half_r <= '0;
      scan_r <= '0;
      scan_q_v_r <= 1'b0;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_v_r && !out_stall) out_v_r <= 1'b0;
      if (wen_p) pvalid_r[waddr_r] <= 1'b1;
      if (wen_e) evalid_r[waddr_r] <= 1'b1;
      unique case (state_r)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            req_r <= in_data;
            half_r <= 2'b00;
            rdata_r <= '0;
          end
        end
        S_READ: begin
          waddr_r <= raddr;
          word_in_r <= word_in;
          half_r[1] <= 1'b1;
        end
        S_MOD: begin
          if (arr_hit && req_r.cmd == mif_pkg::CMD_RD && word_in_r) begin
            if (half_r[0]) rdata_r[63:32] <= is_pend ? pw : ew;
            else rdata_r[31:0] <= is_pend ? pw : ew;
          end
          if (req_r.cmd == mif_pkg::CMD_WR && reg_ok) begin
            if (req_r.sel == mif_pkg::SEL_DELIVERY && !half_r[0]) begin
              if (aplic_r && dwv == mif_pkg::APLIC_VALUE) deliv_r <= dwv[30:0];
              else deliv_r <= {30'd0, dwv[0]};
            end
            if (req_r.sel == mif_pkg::SEL_THRESHOLD && !half_r[0])
              thr_r <= req_r.wdata[7:0] & thr_mask_r;
          end
          if (req_r.cmd == mif_pkg::CMD_RD && reg_ok) begin
            if (req_r.sel == mif_pkg::SEL_DELIVERY) rdata_r <= {33'd0, deliv_r};
            if (req_r.sel == mif_pkg::SEL_THRESHOLD) rdata_r <= {56'd0, thr_r};
          end
          half_r <= {1'b0, 1'b1};
          scan_r <= '0;
          scan_q_v_r <= 1'b0;
          found_r <= 1'b0;
          ok_r <= (req_r.cmd == mif_pkg::CMD_MSG) ? (req_r.access_bytes == 4'd4) :
                  (req_r.cmd == mif_pkg::CMD_RD || req_r.cmd == mif_pkg::CMD_WR) && reg_ok;
        end
        S_SCAN: begin
          // advance one word a cycle; the registered word is checked in the next cycle
          scan_q_v_r <= mem_rd;
          scan_q_r <= scan_r[mif_pkg::WA_W-1:0];
          if (mem_rd) scan_r <= scan_r + 1'b1;
          if (scan_q_v_r && lsb_v && !found_r) begin
            found_r <= 1'b1;
            top_r <= (thr_r == 8'd0 || cand_base < thr_r) ? cand_base : 8'd0;
          end
          if (!scan_q_v_r && scan_r == (mif_pkg::WA_W+1)'(mif_pkg::NUM_WORDS) && !found_r)
            top_r <= 8'd0;
        end
        S_DONE: begin
          // message of wrong size or unknown command leaves state as is
          out_v_r <= 1'b1;
          out_r.ok <= ok_r;
          out_r.rdata <= (req_r.cmd == mif_pkg::CMD_RD && ok_r) ? rdata_r : 64'd0;
          out_r.top_id <= top_r;
          out_r.irq <= req_r.cmd == mif_pkg::CMD_MSG && ok_r &&
                       deliv_r == 31'd1 && top_r != 8'd0;
        end
        default: ;
      endcase
    end
  end

  assign out_valid = out_v_r;
  assign out_data = out_r;

  `MIF_ASSERT_IMP(a_stall_busy, clk, rst_n, state_r != S_IDLE, in_stall)
  `MIF_ASSERT_NXT(a_done_out, clk, rst_n, state_r == S_DONE, out_v_r)
  `MIF_ASSERT_IMP(a_one_write, clk, rst_n, wen_p || wen_e, state_r == S_MOD)
endmodule

// File: tb/sv/tb_top.sv
// Testbench for the interrupt file: directed and random register and message traffic.
`timescale 1ns / 100ps
module tb_top;
  // Selector ranges of the indirect register space.
  localparam logic [7:0] SEL_PRIO_LO = 8'h30;
  localparam logic [7:0] SEL_RES0 = 8'h71;
  localparam logic [7:0] SEL_PEND_LO = 8'h80;
  localparam logic [7:0] SEL_ENA_LO = 8'hC0;
  localparam logic [1:0] CMD_BAD = 2'd3;
  localparam int LIMIT_CYCLES = 400000;

  // Expected results in order, plus the file's own state, kept in the class.
  class irq_file_scoreboard;
    mif_pkg::out_t expected_q[$];
    bit pend[mif_pkg::NUM_IDS];
    bit ena[mif_pkg::NUM_IDS];
    logic [30:0] delivery;
    logic [7:0] threshold;
    logic [7:0] thr_mask;
    bit aplic;
    int mismatches;

    function new();
      delivery = '0;
      threshold = '0;
      thr_mask = 8'hFF;
      aplic = 0;
      mismatches = 0;
    endfunction

    function logic [7:0] lowest_pending();
      for (int i = 1; i < mif_pkg::NUM_IDS; i++) begin
        if (threshold != 0 && i >= threshold) return 8'd0;
        if (pend[i] && ena[i]) return i[7:0];
      end
      return 8'd0;
    endfunction

    // Apply an array or register access; returns ok.
    function bit reg_op(bit wr, logic [7:0] sel, int bits, logic [63:0] v,
                        output logic [63:0] rd);
      int off, lo, hi;
      bit is_pend;
      rd = '0;
      if (bits == 32) v[63:32] = '0;
      if (sel == SEL_RES0 || (sel >= 8'h73 && sel <= 8'h7F)) return 1;
      if (sel >= SEL_PRIO_LO && sel <= 8'h3F) return 1;
      if (sel == mif_pkg::SEL_DELIVERY) begin
        if (wr) begin
          if (!(aplic && v == 64'(mif_pkg::APLIC_VALUE))) v = v & 64'd1;
          delivery = v[30:0];
        end else rd = 64'(delivery);
        return 1;
      end
      if (sel == mif_pkg::SEL_THRESHOLD) begin
        if (wr) threshold = v[7:0] & thr_mask;
        else rd = 64'(threshold);
        return 1;
      end
      if (sel >= SEL_ENA_LO) begin
        off = sel - SEL_ENA_LO;
        is_pend = 0;
      end else if (sel >= SEL_PEND_LO) begin
        off = sel - SEL_PEND_LO;
        is_pend = 1;
      end else return 0;
      if (bits == 64 && off[0]) return 0;
      lo = off * 32;
      hi = lo + bits;
      if (hi > mif_pkg::NUM_IDS) hi = mif_pkg::NUM_IDS;
      if (wr && off == 0) v[0] = 1'b0;
      for (int i = lo; i < hi; i++) begin
        if (wr) begin
          if (is_pend) pend[i] = v[i - lo];
          else ena[i] = v[i - lo];
        end else rd[i - lo] = is_pend ? pend[i] : ena[i];
      end
      return 1;
    endfunction

    function void note_input(mif_pkg::in_t t);
      mif_pkg::out_t e;
      logic [63:0] rd, id;
      e = '0;
      rd = '0;
      if (t.cmd == mif_pkg::CMD_RD || t.cmd == mif_pkg::CMD_WR) begin
        if (t.access_bytes == 4 || t.access_bytes == 8)
          e.ok = reg_op(t.cmd == mif_pkg::CMD_WR, t.sel, t.access_bytes * 8, t.wdata, rd);
        e.rdata = (t.cmd == mif_pkg::CMD_WR) ? '0 : rd;
        e.top_id = lowest_pending();
      end else if (t.cmd == mif_pkg::CMD_MSG) begin
        if (t.access_bytes == 4) begin
          e.ok = 1;
          id = {32'd0, t.wdata[31:0]};
          if (t.page_offset == 4)
            id = {32'd0, id[7:0], id[15:8], id[23:16], id[31:24]};
          if ((t.page_offset == 0 || t.page_offset == 4) && id != 0 &&
              id < mif_pkg::NUM_IDS)
            pend[id] = 1;
          e.top_id = lowest_pending();
          e.irq = (delivery == 1 && e.top_id != 0);
        end else e.top_id = lowest_pending();
      end else e.top_id = lowest_pending();
      // Unknown command or bad message size: top_id is the lowest pending identity of the unchanged state.
      expected_q.push_back(e);
    endfunction

    function void check_result(mif_pkg::out_t got);
      mif_pkg::out_t e;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      e = expected_q.pop_front();
      if (got.ok !== e.ok || got.rdata !== e.rdata || got.top_id !== e.top_id ||
          got.irq !== e.irq) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: exp ok=%0d rdata=%h top=%0d irq=%0d,",
                    " got ok=%0d rdata=%h top=%0d irq=%0d"},
                   e.ok, e.rdata, e.top_id, e.irq, got.ok, got.rdata, got.top_id, got.irq);
      end
    endfunction
  endclass

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, in_stall, out_valid, out_stall = 0;
  mif_pkg::in_t in_data = '0;
  mif_pkg::out_t out_data;
  logic cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0, cfg_pready;
  logic [2:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0, cfg_prdata;

  irq_file_scoreboard sb = new();
  bit sender_idles = 1, receiver_idles = 1;
  int long_hold = 0;
  int cycle_count = 0;

  always #5 clk = ~clk;

  msi_interrupt_file dut (.*);

  // Check every accepted result; count cycles against the limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
    if (cycle_count > LIMIT_CYCLES) begin
      $display("** msi_interrupt_file: FAILED **");
      $finish;
    end
  end

  // Receiver: random stall bursts, or a long hold when asked.
  initial begin
    forever begin
      @(negedge clk);
      if (long_hold > 0) begin
        out_stall <= 1;
        long_hold--;
      end else if (receiver_idles && $urandom_range(0, 5) == 0) begin
        out_stall <= 1;
        repeat ($urandom_range(1, 5) - 1) @(negedge clk);
      end else out_stall <= 0;
    end
  end

  // Offer one transaction and hold it until the block takes it.
  task automatic send(mif_pkg::in_t t);
    if (sender_idles && $urandom_range(0, 5) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_valid <= 1;
    in_data <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(t);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.expected_q.size() != 0) @(negedge clk);
  endtask

  // Write one configuration register while idle; setup then access.
  task automatic cfg_write(logic [1:0] idx, logic [31:0] v);
    drain();
    repeat (20) @(negedge clk);
    cfg_psel <= 1; cfg_pwrite <= 1; cfg_paddr <= {idx[0], 2'b00}; cfg_pwdata <= v;
    @(negedge clk);
    cfg_penable <= 1;
    @(negedge clk);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
    if (idx == mif_pkg::REG_THR_MASK) sb.thr_mask = v[7:0];
    else sb.aplic = v[0];
  endtask

  function automatic mif_pkg::in_t make(logic [1:0] c, logic [7:0] s, logic [3:0] b,
                                        logic [11:0] o, logic [63:0] w);
    mif_pkg::in_t t;
    t.cmd = c; t.sel = s; t.access_bytes = b; t.page_offset = o; t.wdata = w;
    return t;
  endfunction

  // Random transaction, mostly well-formed with useful selects and identities.
  function automatic mif_pkg::in_t rand_item();
    mif_pkg::in_t t;
    int k;
    t = make(2'($urandom_range(0, 3)), 8'($urandom), 4'($urandom), 12'($urandom),
             {$urandom, $urandom});
    k = $urandom_range(0, 19);
    if (k < 17) begin
      t.access_bytes = $urandom_range(0, 1) ? 4'd4 : 4'd8;
      if (k < 6) t.cmd = mif_pkg::CMD_MSG;
      else if (k < 10) t.cmd = mif_pkg::CMD_RD;
      else if (k < 14) t.cmd = mif_pkg::CMD_WR;
    end
    if (t.cmd == mif_pkg::CMD_MSG && k < 15) begin
      t.access_bytes = 4;
      t.page_offset = 12'($urandom_range(0, 1) * 4);
      t.wdata[31:0] = $urandom_range(0, 300);
      if (t.page_offset == 4) t.wdata[31:0] = {<<8{t.wdata[31:0]}};
    end else if (k < 14) begin
      case ($urandom_range(0, 4))
        0: t.sel = mif_pkg::SEL_DELIVERY;
        1: t.sel = mif_pkg::SEL_THRESHOLD;
        2: t.sel = 8'(SEL_PEND_LO + $urandom_range(0, 9));
        3: t.sel = 8'(SEL_ENA_LO + $urandom_range(0, 9));
        default: ;
      endcase
      if (t.sel == mif_pkg::SEL_THRESHOLD && $urandom_range(0, 1)) t.wdata = 0;
      if (t.sel == mif_pkg::SEL_DELIVERY && $urandom_range(0, 2) == 0)
        t.wdata = 64'(mif_pkg::APLIC_VALUE);
    end
    return t;
  endfunction

  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    // Directed: enable words 0 to 3 and 7, mark identities, each select class and special case.
    send(make(mif_pkg::CMD_WR, SEL_ENA_LO, 8, 0, '1));
    send(make(mif_pkg::CMD_WR, SEL_ENA_LO + 8'd2, 8, 0, '1));
    send(make(mif_pkg::CMD_WR, SEL_ENA_LO + 8'd7, 4, 0, '1));
    send(make(mif_pkg::CMD_WR, mif_pkg::SEL_DELIVERY, 4, 0, 64'hFFFF_FFFF_0000_0001));
    send(make(mif_pkg::CMD_MSG, 0, 4, 0, 0));
    send(make(mif_pkg::CMD_MSG, 0, 4, 0, 255));
    send(make(mif_pkg::CMD_MSG, 0, 4, 4, 64'h0500_0000));
    send(make(mif_pkg::CMD_MSG, 0, 4, 8, 3));
    send(make(mif_pkg::CMD_MSG, 0, 8, 0, 3));
    send(make(mif_pkg::CMD_MSG, 0, 4, 0, 256));
    send(make(mif_pkg::CMD_RD, SEL_PEND_LO, 8, 0, 0));
    send(make(mif_pkg::CMD_RD, SEL_PEND_LO + 8'd1, 8, 0, 0));
    send(make(mif_pkg::CMD_RD, SEL_PEND_LO + 8'd7, 4, 0, 0));
    send(make(mif_pkg::CMD_WR, mif_pkg::SEL_THRESHOLD, 4, 0, 4));
    send(make(mif_pkg::CMD_RD, mif_pkg::SEL_THRESHOLD, 8, 0, 0));
    send(make(mif_pkg::CMD_WR, SEL_PRIO_LO, 4, 0, '1));
    send(make(mif_pkg::CMD_RD, 8'h3F, 4, 0, 0));
    send(make(mif_pkg::CMD_RD, SEL_RES0, 4, 0, 0));
    send(make(mif_pkg::CMD_RD, 8'h7F, 8, 0, 0));
    send(make(mif_pkg::CMD_RD, 8'h10, 4, 0, 0));
    send(make(mif_pkg::CMD_RD, 8'h40, 4, 0, 0));
    send(make(mif_pkg::CMD_WR, SEL_PEND_LO, 2, 0, '1));
    send(make(CMD_BAD, SEL_PEND_LO, 4, 0, '1));
    send(make(mif_pkg::CMD_WR, SEL_PEND_LO, 8, 0, '1));
    send(make(mif_pkg::CMD_RD, mif_pkg::SEL_DELIVERY, 4, 0, 0));
    // Random phases across configuration settings, extremes included.
    for (int ph = 0; ph < 6; ph++) begin
      cfg_write(mif_pkg::REG_THR_MASK,
                ph == 0 ? 32'h0 : ph == 1 ? 32'hFF : $urandom_range(0, 255));
      cfg_write(mif_pkg::REG_APLIC, ph % 2);
      if (ph == 5) begin
        sender_idles = 0;
        receiver_idles = 0;
      end
      for (int n = 0; n < 170; n++) begin
        if (ph == 2 && n == 10) long_hold = 200;
        if (ph == 3 && n == 20) drain();
        send(rand_item());
      end
    end
    drain();
    repeat (30) @(negedge clk);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("** msi_interrupt_file: PASSED **");
    end else begin
      $display("** msi_interrupt_file: FAILED **");
    end
    $finish;
  end
endmodule

// File: filelist.f
+incdir+hdl
hdl/mif_pkg.sv
hdl/msi_interrupt_file.sv
tb/sv/tb_top.sv
